// ----- rtl/lfga_pkg.sv -----
// Package for the lowest-free gate allocator: sizes, codes and word types.
// No dependencies.
package lfga_pkg;
	localparam int MaxGates = 64;
	localparam int GateW = 6;             // index bits for MaxGates
	localparam int NumW = 7;
	localparam int TimeW = 32;
	localparam int ServedW = 24;
	localparam int TotalW = 25;
	localparam int SumW = 31;
	localparam logic [ServedW-1:0] ServedMax = {ServedW{1'b1}};
	localparam logic [TotalW-1:0] TotalMax = 25'd33554430;
	localparam logic CmdAlloc = 1'b0;
	localparam logic CmdFinish = 1'b1;
	localparam logic [NumW-1:0] NumReset = 7'd1;

	typedef struct packed {
		logic cmd;
		logic pool;
		logic [TimeW-1:0] arrive_time;
		logic [TimeW-1:0] depart_time;
	} req_t;

	typedef struct packed {
		logic granted;
		logic [NumW-1:0] gate_number;
		logic [TotalW-1:0] best_total;
	} rsp_t;
endpackage

// ----- rtl/lfga_if.sv -----
// Valid/ready channel interface carrying one word of a given type.
// Depends on lfga_pkg for the payload types.
interface lfga_req_if;
	logic valid;
	logic ready;
	lfga_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lfga_rsp_if;
	logic valid;
	logic ready;
	lfga_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/lowest_free_gate_allocator.sv -----
// Top level of the lowest-free gate allocator: APB register, front and back.
// Depends on lfga_pkg, lfga_if, lfga_front and lfga_back.
//
// Two pools of up to 64 gates. A request frees gates whose end time is at or
// before its arrival and grants the lowest free gate; its result is registered
// in the grant state after it leaves the front queue, and the back end takes a
// new word only from its idle state. A finish word scans the served counts one
// gate a cycle; its result is registered after the scan and best-split states.
// An unread result holds the back end. The front queue holds two words so input
// is taken while the back end works.
module lowest_free_gate_allocator (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	lfga_req_if.sink req,
	lfga_rsp_if.source rsp
);
	localparam logic [1:0] AddrNumGates = 2'd0;

	logic [lfga_pkg::NumW-1:0] num_gates_q;
	logic q_valid, q_take;
	lfga_pkg::req_t q_data;

	assign pready = 1'b1;
	assign prdata = (paddr == AddrNumGates) ? {25'd0, num_gates_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_gates_q <= lfga_pkg::NumReset;
		end else if (psel && penable && pwrite && paddr == AddrNumGates) begin
			num_gates_q <= pwdata[lfga_pkg::NumW-1:0];
		end
	end

	lfga_front u_front (
		.clk(clk), .arst_n(arst_n), .in(req),
		.q_valid(q_valid), .q_data(q_data), .q_take(q_take)
	);

	lfga_back u_back (
		.clk(clk), .arst_n(arst_n), .num_gates(num_gates_q),
		.q_valid(q_valid), .q_data(q_data), .q_take(q_take), .out(rsp)
	);

`ifndef SYNTHESIS
	a_grant_gate: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.data.granted == (rsp.data.gate_number != '0)))
		else $error("grant flag and gate number disagree");
	a_grant_total: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.granted) |-> rsp.data.best_total == '0)
		else $error("total on grant");
	a_gate_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.data.gate_number <= lfga_pkg::NumW'(lfga_pkg::MaxGates))
		else $error("gate out of range");
`endif
endmodule

// ----- rtl/lfga_front.sv -----
// Front end: accepts request words into a two-entry queue.
// Depends on lfga_pkg and lfga_if.
module lfga_front (
	input logic clk,
	input logic arst_n,
	lfga_req_if.sink in,
	output logic q_valid,
	output lfga_pkg::req_t q_data,
	input logic q_take
);
	lfga_pkg::req_t buf_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic push;

	assign in.ready = (cnt_q != 2'd2);
	assign push = in.valid && in.ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= in.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_take) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_take};
		end
	end
endmodule

// ----- rtl/lfga_back.sv -----
// Back end: frees, grants and runs the best-split scan; holds gate state.
// Depends on lfga_pkg and lfga_if.
module lfga_back (
	input logic clk,
	input logic arst_n,
	input logic [lfga_pkg::NumW-1:0] num_gates,
	input logic q_valid,
	input lfga_pkg::req_t q_data,
	output logic q_take,
	lfga_rsp_if.source out
);
	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StGrant = 2'd1;
	localparam logic [1:0] StScan = 2'd2;
	localparam logic [1:0] StBest = 2'd3;

	logic [1:0] state_q;
	logic [2*lfga_pkg::MaxGates-1:0] busy_q;
	logic [lfga_pkg::TimeW-1:0] end_q [2*lfga_pkg::MaxGates];
	// served counts: memory with two registered read ports and one write port;
	// an entry never written reads as zero through its valid bit
	logic [lfga_pkg::ServedW-1:0] served_q [2*lfga_pkg::MaxGates];
	logic [2*lfga_pkg::MaxGates-1:0] served_vld_q;
	lfga_pkg::req_t req_q;
	logic [lfga_pkg::MaxGates-1:0] free_q;
	logic [lfga_pkg::NumW-1:0] n_q, k_q;
	logic [lfga_pkg::SumW-1:0] p0_q, p1_q, total1_q, best_q;
	logic scan_rd_s1, bump_s1;
	logic [lfga_pkg::GateW:0] ra_addr, rb_addr, bump_addr_s1;
	logic [lfga_pkg::ServedW-1:0] ra_data_s1, rb_data_s1;
	logic ra_vld_s1, rb_vld_s1;
	logic [lfga_pkg::ServedW-1:0] ra_val, rb_val, bump_val;
	logic [lfga_pkg::NumW-1:0] k_nxt, n_m1, n_k2;
	logic [lfga_pkg::NumW-1:0] n_eff;
	logic [lfga_pkg::MaxGates-1:0] in_use, avail;
	logic [lfga_pkg::GateW-1:0] pick;
	logic found;
	logic [lfga_pkg::SumW-1:0] cand;
	logic out_full, emit;

	assign n_eff = (num_gates > lfga_pkg::NumW'(lfga_pkg::MaxGates))
		? lfga_pkg::NumW'(lfga_pkg::MaxGates) : num_gates;
	always_comb begin
		for (int g = 0; g < lfga_pkg::MaxGates; g++) begin
			in_use[g] = (lfga_pkg::NumW'(g) < n_eff);
		end
	end
	assign out_full = out.valid && !out.ready;
	assign q_take = (state_q == StIdle) && q_valid;
	assign emit = !out_full
		&& ((state_q == StGrant) || (state_q == StBest && k_q == n_q));

	// free-and-pick: lowest gate not busy after freeing
	always_comb begin
		pick = '0;
		found = 1'b0;
		for (int g = lfga_pkg::MaxGates - 1; g >= 0; g--) begin
			if (avail[g]) begin
				pick = lfga_pkg::GateW'(g);
				found = 1'b1;
			end
		end
	end
	assign avail = free_q;

	assign ra_val = ra_vld_s1 ? ra_data_s1 : '0;
	assign rb_val = rb_vld_s1 ? rb_data_s1 : '0;
	assign bump_val = (ra_val == lfga_pkg::ServedMax) ? ra_val : ra_val + 1'b1;
	assign cand = p0_q + total1_q;

	assign k_nxt = k_q + 1'b1;
	assign n_m1 = n_q - 1'b1;
	assign n_k2 = n_q - k_q - lfga_pkg::NumW'(2);

	// read data is registered: addresses are given the cycle before the data they return
	always_comb begin
		unique case (state_q)
			StGrant: begin
				ra_addr = {req_q.pool, pick};
				rb_addr = '0;
			end
			StScan: begin
				ra_addr = (k_q != n_q) ? {1'b1, k_q[lfga_pkg::GateW-1:0]} : '0;
				rb_addr = {1'b1, n_m1[lfga_pkg::GateW-1:0]};
			end
			StBest: begin
				ra_addr = {1'b0, k_nxt[lfga_pkg::GateW-1:0]};
				rb_addr = {1'b1, n_k2[lfga_pkg::GateW-1:0]};
			end
			default: begin
				ra_addr = '0;
				rb_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_take) begin
			req_q <= q_data;
			for (int g = 0; g < lfga_pkg::MaxGates; g++) begin
				free_q[g] <= in_use[g] && (!busy_q[{q_data.pool, 6'(g)}]
					|| end_q[{q_data.pool, 6'(g)}] <= q_data.arrive_time);
			end
		end
		if (state_q == StGrant && found && !out_full) begin
			end_q[{req_q.pool, pick}] <= req_q.depart_time;
		end
		ra_data_s1 <= served_q[ra_addr];
		rb_data_s1 <= served_q[rb_addr];
		ra_vld_s1 <= served_vld_q[ra_addr];
		rb_vld_s1 <= served_vld_q[rb_addr];
		bump_addr_s1 <= ra_addr;
		// count bump lands in the idle cycle after a grant
		if (bump_s1) served_q[bump_addr_s1] <= bump_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			busy_q <= '0;
			served_vld_q <= '0;
			bump_s1 <= 1'b0;
			scan_rd_s1 <= 1'b0;
			out.valid <= 1'b0;
			out.data <= '0;
			n_q <= '0;
			k_q <= '0;
			p0_q <= '0;
			p1_q <= '0;
			total1_q <= '0;
			best_q <= '0;
		end else begin
			if (emit) out.valid <= 1'b1;
			else if (out.valid && out.ready) out.valid <= 1'b0;
			bump_s1 <= (state_q == StGrant) && !out_full && found;
			if (bump_s1) served_vld_q[bump_addr_s1] <= 1'b1;
			unique case (state_q)
				StIdle: begin
					if (q_take) begin
						n_q <= n_eff;
						k_q <= '0;
						p0_q <= '0;
						p1_q <= '0;
						state_q <= (q_data.cmd == lfga_pkg::CmdFinish) ? StScan : StGrant;
					end
				end
				StGrant: begin
					if (!out_full) begin
						for (int g = 0; g < lfga_pkg::MaxGates; g++) begin
							if (in_use[g] && free_q[g]
								&& !(found && pick == lfga_pkg::GateW'(g)))
								busy_q[{req_q.pool, 6'(g)}] <= 1'b0;
						end
						if (found) begin
							busy_q[{req_q.pool, pick}] <= 1'b1;
						end
						out.data.granted <= found;
						out.data.gate_number <= found ? lfga_pkg::NumW'(pick) + 1'b1 : '0;
						out.data.best_total <= '0;
						state_q <= StIdle;
					end
				end
				StScan: begin
					// total of pool 1 over gates 1..n, one gate a cycle
					if (scan_rd_s1) p1_q <= p1_q + lfga_pkg::SumW'(ra_val);
					if (k_q != n_q) begin
						scan_rd_s1 <= 1'b1;
						k_q <= k_q + 1'b1;
					end else begin
						scan_rd_s1 <= 1'b0;
						if (!scan_rd_s1) begin
							total1_q <= p1_q;
							best_q <= p1_q;
							k_q <= '0;
							state_q <= StBest;
						end
					end
				end
				StBest: begin
					// cand = pool0 prefix(k) + pool1 prefix(n-k), stepping k
					if (cand > best_q) best_q <= cand;
					if (k_q == n_q) begin
						if (!out_full) begin
							out.data.granted <= 1'b0;
							out.data.gate_number <= '0;
							out.data.best_total <=
								(((cand > best_q) ? cand : best_q) > lfga_pkg::SumW'(lfga_pkg::TotalMax))
								? lfga_pkg::TotalMax
								: lfga_pkg::TotalW'((cand > best_q) ? cand : best_q);
							state_q <= StIdle;
						end
					end else begin
						p0_q <= p0_q + lfga_pkg::SumW'(ra_val);
						total1_q <= total1_q - lfga_pkg::SumW'(rb_val);
						k_q <= k_q + 1'b1;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end
endmodule

// ----- sim/lowest_free_gate_allocator_tb.sv -----
// Testbench for the lowest-free gate allocator: drives requests and finish words
// through the request channel, checks every response against a local predictor.
// Depends on lfga_pkg, lfga_if and the lowest_free_gate_allocator RTL.
module lowest_free_gate_allocator_tb;
	localparam logic [1:0] RegNumGates = 2'd0;
	localparam int CycleLimit = 1000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	lfga_req_if req ();
	lfga_rsp_if rsp ();

	lowest_free_gate_allocator dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req(req.sink), .rsp(rsp.source)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	logic [lfga_pkg::NumW-1:0] num_gates_q;
	logic busy_q [2][lfga_pkg::MaxGates];
	logic [lfga_pkg::TimeW-1:0] end_q [2][lfga_pkg::MaxGates];
	logic [lfga_pkg::ServedW-1:0] served_q [2][lfga_pkg::MaxGates];
	logic [lfga_pkg::TimeW-1:0] last_arrive [2];

	lfga_pkg::rsp_t pending_rsp [$];
	int errors = 0;
	int cycles = 0;
	bit hold_off = 0;
	bit stim_done = 0;

	task automatic report(input string what, input lfga_pkg::rsp_t got,
		input lfga_pkg::rsp_t exp);
		errors++;
		$display("ERROR %s: got g=%0b n=%0d t=%0d exp g=%0b n=%0d t=%0d", what,
			got.granted, got.gate_number, got.best_total,
			exp.granted, exp.gate_number, exp.best_total);
	endtask

	function automatic lfga_pkg::rsp_t predict_grant(input lfga_pkg::req_t r);
		lfga_pkg::rsp_t o;
		int n;
		longint best, s0, s1;
		o = '0;
		n = (num_gates_q > lfga_pkg::MaxGates) ? lfga_pkg::MaxGates : num_gates_q;
		if (r.cmd == lfga_pkg::CmdFinish) begin
			best = 0;
			for (int k = 0; k <= n; k++) begin
				s0 = 0;
				s1 = 0;
				for (int g = 0; g < k; g++) s0 += served_q[0][g];
				for (int g = 0; g < n - k; g++) s1 += served_q[1][g];
				if (s0 + s1 > best) best = s0 + s1;
			end
			if (best > lfga_pkg::TotalMax) best = lfga_pkg::TotalMax;
			o.best_total = best[lfga_pkg::TotalW-1:0];
			return o;
		end
		for (int g = 0; g < n; g++)
			if (busy_q[r.pool][g] && end_q[r.pool][g] <= r.arrive_time)
				busy_q[r.pool][g] = 1'b0;
		for (int g = 0; g < n; g++) begin
			if (!busy_q[r.pool][g]) begin
				busy_q[r.pool][g] = 1'b1;
				end_q[r.pool][g] = r.depart_time;
				if (served_q[r.pool][g] != lfga_pkg::ServedMax) served_q[r.pool][g]++;
				o.granted = 1'b1;
				o.gate_number = lfga_pkg::NumW'(g + 1);
				break;
			end
		end
		return o;
	endfunction

	// sender: one word, after a random gap; valid stays up when there is no gap
	task automatic send_word(input lfga_pkg::req_t r);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.data <= r;
		req.valid <= 1'b1;
		do @(posedge clk); while (!req.ready);
		pending_rsp.push_back(predict_grant(r));
		@(negedge clk);
		if (r.cmd == lfga_pkg::CmdAlloc) last_arrive[r.pool] = r.arrive_time;
	endtask

	task automatic wait_drain();
		req.valid <= 1'b0;
		while (pending_rsp.size() != 0) @(negedge clk);
		repeat (2 * lfga_pkg::MaxGates + 20) @(negedge clk);
	endtask

	task automatic write_num_gates(input logic [lfga_pkg::NumW-1:0] v);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= RegNumGates;
		pwdata <= 32'(v);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		num_gates_q = v;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic lfga_pkg::req_t mk(input logic c, input logic p,
		input logic [31:0] a, input logic [31:0] d);
		lfga_pkg::req_t r;
		r.cmd = c;
		r.pool = p;
		r.arrive_time = a;
		r.depart_time = d;
		return r;
	endfunction

	// random request: mostly nondecreasing arrivals, sometimes out of order
	function automatic lfga_pkg::req_t rand_req(input bit wide);
		lfga_pkg::req_t r;
		logic p;
		logic [31:0] a;
		p = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 15) == 0) a = $urandom;
		else if (wide) a = last_arrive[p] + $urandom_range(0, 1 << 20);
		else a = last_arrive[p] + $urandom_range(0, 6);
		if (a < last_arrive[p] && $urandom_range(0, 3) != 0) a = last_arrive[p];
		r = mk($urandom_range(0, 24) == 0 ? lfga_pkg::CmdFinish : lfga_pkg::CmdAlloc,
			p, a, wide ? $urandom : a + $urandom_range(0, 40));
		return r;
	endfunction

	typedef struct {
		lfga_pkg::req_t r;
		bit fixed;
		lfga_pkg::rsp_t exp;
	} dir_row_t;

	dir_row_t dir_tbl [$];

	initial begin
		lfga_pkg::rsp_t e;
		req.valid = 1'b0;
		req.data = '0;
		for (int p = 0; p < 2; p++) begin
			last_arrive[p] = '0;
			for (int g = 0; g < lfga_pkg::MaxGates; g++) begin
				busy_q[p][g] = 1'b0;
				end_q[p][g] = '0;
				served_q[p][g] = '0;
			end
		end
		num_gates_q = lfga_pkg::NumReset;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed: reset config of one gate, then extremes
		e = '0; e.granted = 1; e.gate_number = 1;
		dir_tbl.push_back('{mk(lfga_pkg::CmdFinish, 1, '1, '1), 1, lfga_pkg::rsp_t'(0)});
		dir_tbl.push_back('{mk(lfga_pkg::CmdAlloc, 0, 0, 32'hFFFF_FFFF), 1, e});
		dir_tbl.push_back('{mk(lfga_pkg::CmdAlloc, 0, 5, 9), 1, lfga_pkg::rsp_t'(0)});
		dir_tbl.push_back('{mk(lfga_pkg::CmdAlloc, 1, 0, 0), 1, e});
		dir_tbl.push_back('{mk(lfga_pkg::CmdAlloc, 1, 0, 3), 1, e});
		dir_tbl.push_back('{mk(lfga_pkg::CmdAlloc, 0, 32'hFFFF_FFFF, 0), 1, e});
		dir_tbl.push_back('{mk(lfga_pkg::CmdAlloc, 0, 3, 32'hAAAA_5555), 1, e});
		dir_tbl.push_back('{mk(lfga_pkg::CmdFinish, 0, 0, 0), 0, lfga_pkg::rsp_t'(0)});
		foreach (dir_tbl[i]) begin
			send_word(dir_tbl[i].r);
			if (dir_tbl[i].fixed && pending_rsp[$] != dir_tbl[i].exp)
				report("directed table", pending_rsp[$], dir_tbl[i].exp);
		end
		wait_drain();

		// zero gates: everything refused
		write_num_gates(0);
		send_word(mk(lfga_pkg::CmdAlloc, 0, 32'hFFFF_FFFF, 1));
		send_word(mk(lfga_pkg::CmdAlloc, 1, 32'hFFFF_FFFF, 1));
		send_word(mk(lfga_pkg::CmdFinish, 0, 0, 0));
		wait_drain();

		// oversize count acts as the maximum; six allocations per pool, then a finish
		write_num_gates(7'd127);
		for (int i = 0; i < 12; i++)
			send_word(mk(lfga_pkg::CmdAlloc, i[0], 32'd10, 32'h5A5A_0000 | i));
		send_word(mk(lfga_pkg::CmdFinish, 0, 0, 0));
		wait_drain();

		// random phases; the second one has a long output hold-off
		for (int ph = 0; ph < 6; ph++) begin
			logic [lfga_pkg::NumW-1:0] ng;
			case (ph)
				0: ng = 7'd64;
				1: ng = 7'd1;
				2: ng = 7'd65;
				default: ng = lfga_pkg::NumW'($urandom_range(2, 12));
			endcase
			write_num_gates(ng);
			if (ph == 1) hold_off = 1;
			for (int i = 0; i < 140; i++) begin
				lfga_pkg::req_t r;
				r = rand_req(ph == 0);
				send_word(r);
			end
			send_word(mk(lfga_pkg::CmdFinish, 1'($urandom), $urandom, $urandom));
			wait_drain();
		end
		write_num_gates(7'd3);
		stim_done = 1;
	end

	// receiver
	initial begin
		int stall;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				rsp.ready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_off = 0;
			end
			stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 16);
			if (stall != 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
		end
	end

	// checker
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_rsp.size() == 0) begin
				report("unexpected word", rsp.data, lfga_pkg::rsp_t'(0));
			end else begin
				lfga_pkg::rsp_t x;
				x = pending_rsp.pop_front();
				if (rsp.data.granted !== x.granted) report("granted", rsp.data, x);
				if (rsp.data.gate_number !== x.gate_number)
					report("gate_number", rsp.data, x);
				if (rsp.data.best_total !== x.best_total)
					report("best_total", rsp.data, x);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (stim_done) begin
			// wait_drain already passed; allow a margin for late extras
			repeat (2 * lfga_pkg::MaxGates + 20) @(posedge clk);
			if (errors == 0 && pending_rsp.size() == 0) begin
				$display("No mismatches found");
			end else begin
				$display("Mismatches found");
			end
			$finish;
		end else if (cycles > CycleLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end
endmodule
